// ----- design/cmf_pkg.sv -----
package cmf_pkg;

    localparam int unsigned MAX_WIDTH_DEF  = 1024;
    localparam int unsigned MAX_HEIGHT_DEF = 4096;

    localparam int unsigned CH_W     = 8;
    localparam int unsigned WIDTH_W  = 11;
    localparam int unsigned HEIGHT_W = 13;
    localparam int unsigned CFG_W    = 13;
    localparam int unsigned ROW_W    = 12;
    localparam int unsigned COL_W    = 10;
    localparam int unsigned NPTS     = 5;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd1024;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_e;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } rgb_t;

    typedef struct packed {
        logic apply;
        rgb_t rgb;
    } pix_t;

    // one column of the line store: the row before and the latest row
    typedef struct packed {
        pix_t older;
        pix_t newer;
    } line_t;

    // window: point 0 is the centre, mask bit set where a point is present
    typedef struct packed {
        pix_t [NPTS-1:0] pts;
        logic [NPTS-1:0] mask;
    } win_t;

endpackage

// ----- design/cmf_in_if.sv -----
interface cmf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       apply;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output apply, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input apply, output ready);
endinterface

// ----- design/cmf_out_if.sv -----
interface cmf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        frame_last;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output out_row, output out_col, output frame_last, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input out_row, input out_col, input frame_last, output ready);
endinterface

// ----- design/cmf_median_lane.sv -----
module cmf_median_lane (
    input  logic [cmf_pkg::NPTS-1:0][cmf_pkg::CH_W-1:0] vals,
    input  logic [cmf_pkg::NPTS-1:0]                    mask,
    output logic [cmf_pkg::CH_W-1:0]                    med
);
    import cmf_pkg::*;

    logic [2:0]      rank [NPTS];
    logic [CH_W-1:0] srt  [NPTS];
    logic [2:0]      cnt;
    logic [CH_W:0]   sum_lo;
    logic [CH_W:0]   sum_hi;

    // rank each present point; ties broken by position
    always_comb
    begin
        for (int i = 0; i < NPTS; i++)
        begin
            rank[i] = 3'd0;
            for (int j = 0; j < NPTS; j++)
            begin
                if (j != i && mask[j] &&
                    (vals[j] < vals[i] || (vals[j] == vals[i] && j < i)))
                begin
                    rank[i] = rank[i] + 3'd1;
                end
            end
        end
        for (int k = 0; k < NPTS; k++)
        begin
            srt[k] = '0;
            for (int i = 0; i < NPTS; i++)
            begin
                if (mask[i] && rank[i] == 3'(k))
                begin
                    srt[k] = srt[k] | vals[i];
                end
            end
        end
    end

    assign cnt    = 3'($countones(mask));
    assign sum_lo = {1'b0, srt[0]} + {1'b0, srt[1]};
    assign sum_hi = {1'b0, srt[1]} + {1'b0, srt[2]};

    always_comb
    begin
        case (cnt)
            3'd1:    med = srt[0];
            3'd2:    med = sum_lo[CH_W:1];
            3'd3:    med = srt[1];
            3'd4:    med = sum_hi[CH_W:1];
            default: med = srt[2];
        endcase
    end
endmodule

// ----- design/cmf_window.sv -----
module cmf_window (
    input  cmf_pkg::win_t win,
    output cmf_pkg::rgb_t res
);
    import cmf_pkg::*;

    logic [NPTS-1:0][CH_W-1:0] red_v;
    logic [NPTS-1:0][CH_W-1:0] green_v;
    logic [NPTS-1:0][CH_W-1:0] blue_v;
    rgb_t                      med;

    always_comb
    begin
        for (int i = 0; i < NPTS; i++)
        begin
            red_v[i]   = win.pts[i].rgb.red;
            green_v[i] = win.pts[i].rgb.green;
            blue_v[i]  = win.pts[i].rgb.blue;
        end
    end

    cmf_median_lane u_red   (.vals(red_v),   .mask(win.mask), .med(med.red));
    cmf_median_lane u_green (.vals(green_v), .mask(win.mask), .med(med.green));
    cmf_median_lane u_blue  (.vals(blue_v),  .mask(win.mask), .med(med.blue));

    // the centre's apply bit chooses filtered or original
    assign res = win.pts[0].apply ? med : win.pts[0].rgb;
endmodule

// ----- design/cross_median_filter_rgb_core.sv -----
// Path: the result of the input beat that completes a window passes the window register,
// then the output register.
// Throughput: one beat per cycle while each beat yields at most one result and the
// output is not stalled; on the last row a beat yields up to three results and holds
// input until they leave. Reset: counters clear, image_width and image_height return
// to 1024; the line store is not cleared.
module cross_median_filter_rgb_core #(
    parameter int unsigned MAX_WIDTH  = cmf_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = cmf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    cmf_in_if.sink                     in_px,
    cmf_out_if.source                  out_px,
    input  logic                       cfg_we,
    input  cmf_pkg::reg_idx_e          cfg_index,
    input  logic [cmf_pkg::CFG_W-1:0]  cfg_data
);
    import cmf_pkg::*;

    localparam int unsigned CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned EW = 18;
    localparam int unsigned NSLOT = 3;

    // configuration
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [EW-1:0]       w_eff;
    logic [EW-1:0]       h_eff;

    // raster position of the next input beat
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic          lc;
    logic          lr;

    // line store and the columns held around the current one
    line_t         line_mem [MAX_WIDTH];
    line_t         cur_reg;      // store column c before this beat's write
    line_t         nxt_reg;      // store column c+1
    line_t         row0_reg;     // column 0 as written on this row
    line_t         row1_reg;     // column 1 as written on this row
    line_t         left1_reg;    // column c-1 after its write
    pix_t          left2_reg;    // newest pixel at column c-2
    line_t         wd;
    pix_t          px;
    logic [CW-1:0] rd_addr;

    // windows awaiting output
    win_t          win_reg  [NSLOT];
    win_t          win_next [NSLOT];
    logic [RW-1:0] srow_reg [NSLOT];
    logic [CW-1:0] scol_reg [NSLOT];
    logic [NSLOT-1:0] pend_reg;
    logic [NSLOT-1:0] pend_next;
    rgb_t          res      [NSLOT];
    logic [1:0]    sel;
    logic          move;
    logic          accept;

    // output register
    logic          ovalid_reg;
    rgb_t          orgb_reg;
    logic [RW-1:0] orow_reg;
    logic [CW-1:0] ocol_reg;
    logic          olast_reg;

    // clamp the frame size into the supported range
    assign w_eff = (width_reg == '0) ? EW'(1) :
                   (EW'(width_reg) > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(width_reg);
    assign h_eff = (height_reg == '0) ? EW'(1) :
                   (EW'(height_reg) > EW'(MAX_HEIGHT)) ? EW'(MAX_HEIGHT) : EW'(height_reg);

    // a counter at or past the edge counts as the edge
    assign lc = (EW'(col_reg) + EW'(1)) >= w_eff;
    assign lr = (EW'(row_reg) + EW'(1)) >= h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    // incoming pixel and the store entry written for its column
    assign px.rgb.red   = in_px.red_in;
    assign px.rgb.green = in_px.green_in;
    assign px.rgb.blue  = in_px.blue_in;
    assign px.apply     = in_px.apply;
    assign wd.older     = cur_reg.newer;
    assign wd.newer     = px;

    assign rd_addr = CW'({1'b0, col_reg} + (CW+1)'(2));

    // take a beat when the windows are empty or the last one leaves now
    assign move         = (pend_reg != '0) && (!ovalid_reg || out_px.ready);
    assign in_px.ready  = (pend_reg == '0) ||
                          (((pend_reg & (pend_reg - NSLOT'(1))) == '0) && move);
    assign accept       = in_px.valid && in_px.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (lc)
            begin
                col_reg <= '0;
                row_reg <= lr ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // line store: write column c, fetch column c+2 ahead of need;
    // at a row wrap columns 0 and 1 come from the copies kept this row
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_mem[col_reg] <= wd;
            if (lc)
            begin
                nxt_reg <= (col_reg == CW'(1)) ? wd : row1_reg;
            end
            else
            begin
                nxt_reg <= line_mem[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (lc)
            begin
                cur_reg <= (col_reg == '0) ? wd : row0_reg;
            end
            else
            begin
                cur_reg <= nxt_reg;
            end
            if (col_reg == '0)
            begin
                row0_reg <= wd;
            end
            if (col_reg == CW'(1))
            begin
                row1_reg <= wd;
            end
            left1_reg <= wd;
            left2_reg <= left1_reg.newer;
        end
    end

    // build the three windows a beat may close
    always_comb
    begin
        for (int s = 0; s < NSLOT; s++)
        begin
            win_next[s] = '0;
        end

        // row above, same column
        win_next[0].pts[0] = cur_reg.newer;
        win_next[0].pts[1] = px;
        win_next[0].pts[2] = left1_reg.older;
        win_next[0].pts[3] = nxt_reg.newer;
        win_next[0].pts[4] = cur_reg.older;
        win_next[0].mask   = {(row_reg >= RW'(2)) && (MAX_HEIGHT > 2), !lc,
                              col_reg != '0, 1'b1, 1'b1};

        // last row, column to the left
        win_next[1].pts[0] = left1_reg.newer;
        win_next[1].pts[1] = px;
        win_next[1].pts[2] = left2_reg;
        win_next[1].pts[3] = left1_reg.older;
        win_next[1].mask   = {1'b0, row_reg != '0,
                              (col_reg >= CW'(2)) && (MAX_WIDTH > 2), 1'b1, 1'b1};

        // last pixel of the frame
        win_next[2].pts[0] = px;
        win_next[2].pts[1] = left1_reg.newer;
        win_next[2].pts[2] = cur_reg.newer;
        win_next[2].mask   = {1'b0, 1'b0, row_reg != '0, col_reg != '0, 1'b1};

        pend_next = {lr && lc, lr && (col_reg != '0), row_reg != '0};
    end

    // first pending window goes out next
    always_comb
    begin
        if (pend_reg[0])
        begin
            sel = 2'd0;
        end
        else if (pend_reg[1])
        begin
            sel = 2'd1;
        end
        else
        begin
            sel = 2'd2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
        end
        else if (move)
        begin
            pend_reg[sel] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int s = 0; s < NSLOT; s++)
            begin
                win_reg[s] <= win_next[s];
            end
            srow_reg[0] <= row_reg - RW'(1);
            scol_reg[0] <= col_reg;
            srow_reg[1] <= row_reg;
            scol_reg[1] <= col_reg - CW'(1);
            srow_reg[2] <= row_reg;
            scol_reg[2] <= col_reg;
        end
    end

    // one filter per window, channels side by side inside each
    for (genvar g = 0; g < NSLOT; g++)
    begin : g_win
        cmf_window u_window (.win(win_reg[g]), .res(res[g]));
    end

    // merge: hand the chosen window's result to the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (move)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_px.ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            orgb_reg  <= res[sel];
            orow_reg  <= srow_reg[sel];
            ocol_reg  <= scol_reg[sel];
            olast_reg <= (sel == 2'd2);
        end
    end

    assign out_px.valid      = ovalid_reg;
    assign out_px.red_out    = orgb_reg.red;
    assign out_px.green_out  = orgb_reg.green;
    assign out_px.blue_out   = orgb_reg.blue;
    assign out_px.out_row    = ROW_W'(orow_reg);
    assign out_px.out_col    = COL_W'(ocol_reg);
    assign out_px.frame_last = olast_reg;
endmodule
